// ----- design/sta_pkg.sv -----
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types, codes and sizes of the slot table allocator.
// ----------------------------------------------------------------------------
package sta_pkg;

   localparam int SLOTS     = 64;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int PAYLOAD_W = 32;
   localparam int CMD_W     = 2;
   localparam int ERR_W     = 2;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_INDEX = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_LAST_SLOT_ADDR = 3'd0;
   localparam logic [SLOT_W-1:0]     LAST_SLOT_RESET    = 6'd63;
   localparam logic [SLOT_W-1:0]     HIGH_WATER_RESET   = 6'd1;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [SLOT_W-1:0]    slot_index;
      logic [PAYLOAD_W-1:0] entry_data;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [ERR_W-1:0]     error_code;
      logic [SLOT_W-1:0]    slot_out;
      logic [PAYLOAD_W-1:0] entry_out;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic commit;
   } ctl_cmd_type;

endpackage

// ----- design/slot_table_allocator.sv -----
// ----------------------------------------------------------------------------
// slot_table_allocator
// First-fit slot table with valid bits, a high-water mark and a register
// port for the last usable slot.
// ----------------------------------------------------------------------------
// sequence: the input item and its payload read are registered on the input
//   transfer, then the find-first and table update run and the result stage
//   is loaded; a new item is taken only once the previous one is committed
// reset: valid bits cleared at once, high-water mark 1, last_slot 63;
//   no clearing pass, items are taken from the first cycle after reset
module slot_table_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sta_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sta_pkg::rsp_type                  rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sta_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sta_pkg::CSR_W-1:0]         pwdata,
   output logic [sta_pkg::CSR_W-1:0]         prdata,
   output logic                              pready
);
   import sta_pkg::*;

   ctl_cmd_type       ctl;
   logic [SLOT_W-1:0] last_slot_ff, last_slot_in;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      last_slot_in = last_slot_ff;
      if (csr_write && (paddr == CSR_LAST_SLOT_ADDR)) begin
         last_slot_in = pwdata[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_slot_ff <= LAST_SLOT_RESET;
      end else begin
         last_slot_ff <= last_slot_in;
      end
   end

   always_comb begin
      unique case (paddr)
         CSR_LAST_SLOT_ADDR: prdata = {{(CSR_W-SLOT_W){1'b0}}, last_slot_ff};
         default:            prdata = '0;
      endcase
   end

   sta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   sta_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_payload (req_payload),
      .last_slot   (last_slot_ff),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in flight");

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.ok == (rsp_payload.error_code == ERR_NONE)))
      else $error("ok flag disagrees with error code");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.ok) |->
         (rsp_payload.slot_out == '0 && rsp_payload.entry_out == '0))
      else $error("error result carries nonzero slot or payload");

   a_insert_slot_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.ok && rsp_payload.slot_out != '0) |->
         (rsp_payload.entry_out == '0))
      else $error("insert result carries payload");
`endif

endmodule

// ----- design/sta_ctrl.sv -----
// ----------------------------------------------------------------------------
// sta_ctrl
// Sequencer of the allocator: takes an item, runs it, loads the result stage.
// ----------------------------------------------------------------------------
module sta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sta_pkg::ctl_cmd_type ctl
);
   import sta_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ctl.load     = 1'b0;
      ctl.commit   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               ctl.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/sta_datapath.sv -----
// ----------------------------------------------------------------------------
// sta_datapath
// Valid bits, high-water mark, payload memory and result stage.
// ----------------------------------------------------------------------------
module sta_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  sta_pkg::ctl_cmd_type        ctl,
   input  sta_pkg::req_type            req_payload,
   input  logic [sta_pkg::SLOT_W-1:0]  last_slot,
   output sta_pkg::rsp_type            rsp_payload
);
   import sta_pkg::*;

   logic [PAYLOAD_W-1:0] mem [SLOTS];

   req_type              item_ff;
   logic [PAYLOAD_W-1:0] rd_data_ff;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOT_W-1:0]    hw_ff, hw_in;
   rsp_type              rsp_ff, res;

   logic [SLOTS-1:0]     free_vec;
   logic [SLOTS-1:0]     first_free;
   logic [SLOT_W-1:0]    sel;
   logic                 found;
   logic                 can_insert;
   logic                 hit;
   logic                 mem_we;

   // lowest free slot from 1 up to the mark
   always_comb begin
      free_vec = '0;
      for (int i = 1; i < SLOTS; i++) begin
         free_vec[i] = !valid_ff[i] && (SLOT_W'(i) <= hw_ff);
      end
   end

   assign first_free = free_vec & (~free_vec + {{(SLOTS-1){1'b0}}, 1'b1});
   assign found      = |free_vec;

   always_comb begin
      sel = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (first_free[i]) sel = sel | SLOT_W'(i);
      end
   end

   assign can_insert = (hw_ff < last_slot) && (hw_ff < SLOT_W'(SLOTS - 1)) && found;
   assign hit        = (item_ff.slot_index <= last_slot) && valid_ff[item_ff.slot_index];

   always_comb begin
      res            = '0;
      res.error_code = ERR_INDEX;
      valid_in       = valid_ff;
      hw_in          = hw_ff;
      mem_we         = 1'b0;
      case (item_ff.command)
         CMD_INSERT: begin
            res.error_code = ERR_FULL;
            if (can_insert) begin
               res.ok         = 1'b1;
               res.error_code = ERR_NONE;
               res.slot_out   = sel;
               valid_in[sel]  = 1'b1;
               mem_we         = 1'b1;
               if (sel == hw_ff) hw_in = hw_ff + SLOT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               res.ok         = 1'b1;
               res.error_code = ERR_NONE;
               valid_in[item_ff.slot_index] = 1'b0;
               if ((item_ff.slot_index != '0) &&
                   (item_ff.slot_index + SLOT_W'(1) == hw_ff)) begin
                  hw_in = hw_ff - SLOT_W'(1);
               end
            end
         end
         CMD_RETRIEVE: begin
            if (hit) begin
               res.ok         = 1'b1;
               res.error_code = ERR_NONE;
               res.entry_out  = rd_data_ff;
            end
         end
         default: res.error_code = ERR_INDEX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         item_ff    <= req_payload;
         rd_data_ff <= mem[req_payload.slot_index];
      end
      if (ctl.commit && mem_we) begin
         mem[sel] <= item_ff.entry_data;
      end
      if (ctl.commit) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hw_ff    <= HIGH_WATER_RESET;
      end else if (ctl.commit) begin
         valid_ff <= valid_in;
         hw_ff    <= hw_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
